>>> design/fsts_pkg.sv
// Shared types and constants for the fair share task scheduler.
// Used by the core (the top level), the divider and the testbench; depends on nothing.
package fsts_pkg;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_W = 8;
	localparam int VR_W = 64;
	localparam int WT_W = 20;
	localparam int GR_W = 32;
	localparam int ST_W = 2;
	localparam int TICK_SCALE = 1000;
	localparam int SLOT_W = ID_W + VR_W + WT_W;

	typedef enum logic [1:0] {
		REQ_ENQ  = 2'd0,
		REQ_DEQ  = 2'd1,
		REQ_PICK = 2'd2,
		REQ_TICK = 2'd3
	} req_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_NOID  = 2'd3
	} status_t;

	localparam logic CFG_WEIGHT = 1'b0;
	localparam logic CFG_GRAN   = 1'b1;
endpackage

>>> design/fair_share_task_scheduler_core.sv
// Fair share task scheduler top level: ready table in a RAM, slot scan sequencer.
// Depends on fsts_pkg, fsts_ram and fsts_div.
//
// Usage: requests arrive on s_axis (tdata = req_type, task_id, task_vruntime,
// task_weight from the lowest bit). One result per request leaves on m_axis.
// Every request is served by a scan of the slot table held in one RAM with a
// registered read. An enqueue or a dequeue goes through the scan, the write
// state and the output state. A pick needs a second scan for the new floor
// after its write state, and a tick waits in the divider state between its
// scan and its write state.
// One item is in flight at a time; s_tready is high in the idle state only,
// so a new request is taken at the earliest in the cycle after a result transfer.
// The result is held in an output register until taken; while the receiver
// stalls no new request is accepted.
// Reset clears all valid bits, the count, the floor, and loads the register defaults;
// the RAM contents need no clearing since data read from invalid slots is ignored.
// Configuration writes land at the next rising edge with cfg_we high.
module fair_share_task_scheduler_core #(
	parameter int QUEUE_DEPTH = fsts_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // req_type, task_id, task_vruntime, task_weight
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_task_id, out_vruntime, out_weight, preempt, status, queue_count, floor_vr
	output logic [167:0] m_tdata,
	input  logic         cfg_we,
	input  logic         cfg_index,
	input  logic [31:0]  cfg_data
);
	import fsts_pkg::*;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_SCAN2, S_DIV, S_WRITE, S_OUT
	} state_t;

	state_t state_q;
	logic [WT_W-1:0] dw_q;
	logic [GR_W-1:0] gran_q;
	logic [QUEUE_DEPTH-1:0] valid_q;
	logic [VR_W-1:0] floor_q;
	logic [CW-1:0] count_q;

	logic [1:0] req_q;
	logic [ID_W-1:0] id_q;
	logic [VR_W-1:0] vr_q;
	logic [WT_W-1:0] wt_q;

	logic [AW:0] idx_q;
	logic [AW-1:0] rd_idx_s1;
	logic rd_vld_s1;
	logic found_q;
	logic [AW-1:0] best_q;
	logic [ID_W-1:0] best_id_q;
	logic [VR_W-1:0] best_vr_q;
	logic [WT_W-1:0] best_wt_q;
	logic [AW-1:0] free_q;
	logic free_ok_q;

	logic [ID_W-1:0] o_id_q;
	logic [VR_W-1:0] o_vr_q;
	logic [WT_W-1:0] o_wt_q;
	logic o_pre_q;
	logic [ST_W-1:0] o_st_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SLOT_W-1:0] ram_wdata, ram_rdata;
	logic [ID_W-1:0] r_id;
	logic [VR_W-1:0] r_vr;
	logic [WT_W-1:0] r_wt;
	logic better;

	logic div_start, div_done;
	logic [29:0] div_quot;
	logic [29:0] div_num;
	logic [WT_W-1:0] div_den;

	assign {r_wt, r_vr, r_id} = ram_rdata;
	assign better = !found_q || r_vr < best_vr_q || (r_vr == best_vr_q && r_id < best_id_q);

	fsts_ram #(.WIDTH(SLOT_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(idx_q[AW-1:0]), .rdata(ram_rdata)
	);

	assign div_num = 30'(dw_q) * 30'(TICK_SCALE);
	assign div_den = (wt_q == '0) ? dw_q : wt_q;
	assign div_start = (state_q == S_SCAN) && (req_q == REQ_TICK) && idx_q == (AW+1)'(QUEUE_DEPTH)
		&& !rd_vld_s1;

	fsts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	assign ram_we = (state_q == S_WRITE) && (req_q == REQ_ENQ) && free_ok_q;
	assign ram_waddr = free_q;
	assign ram_wdata = {(wt_q == '0) ? dw_q : wt_q, (vr_q == '0) ? floor_q : vr_q, id_q};

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata = {4'b0000, floor_q, 5'(count_q), o_st_q, o_pre_q, o_wt_q, o_vr_q, o_id_q};

	logic scan_end;
	logic [VR_W-1:0] nv;
	assign scan_end = (idx_q == (AW+1)'(QUEUE_DEPTH)) && !rd_vld_s1;
	assign nv = vr_q + ((div_den != '0) ? VR_W'(div_quot) : VR_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dw_q <= WT_W'(1024);
			gran_q <= GR_W'(4000);
			valid_q <= '0;
			floor_q <= '0;
			count_q <= '0;
			rd_vld_s1 <= 1'b0;
			idx_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_WEIGHT) dw_q <= cfg_data[WT_W-1:0];
				else gran_q <= cfg_data;
			end
			rd_vld_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						idx_q <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN, S_SCAN2: begin
					if (idx_q != (AW+1)'(QUEUE_DEPTH)) begin
						idx_q <= idx_q + (AW+1)'(1);
						rd_vld_s1 <= 1'b1;
					end
					if (rd_vld_s1 && valid_q[rd_idx_s1] && req_q == REQ_DEQ && r_id == id_q) begin
						valid_q[rd_idx_s1] <= 1'b0;
						count_q <= count_q - CW'(1);
					end
					if (scan_end) begin
						if (state_q == S_SCAN2) begin
							state_q <= S_OUT;
							if (found_q) floor_q <= best_vr_q;
							else floor_q <= o_vr_q;
						end else if (req_q == REQ_TICK) state_q <= S_DIV;
						else state_q <= S_WRITE;
					end
				end
				S_DIV: begin
					if (div_done) state_q <= S_WRITE;
				end
				S_WRITE: begin
					state_q <= S_OUT;
					if (req_q == REQ_ENQ && free_ok_q) begin
						valid_q[free_q] <= 1'b1;
						count_q <= count_q + CW'(1);
					end
					if (req_q == REQ_PICK && found_q) begin
						valid_q[best_q] <= 1'b0;
						count_q <= count_q - CW'(1);
						idx_q <= '0;
						state_q <= S_SCAN2;
					end
				end
				S_OUT: begin
					if (m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[AW-1:0];
		case (state_q)
			S_IDLE: begin
				{wt_q, vr_q, id_q, req_q} <= s_tdata[93:0];
				found_q <= 1'b0;
				free_ok_q <= 1'b0;
				free_q <= '0;
				best_q <= '0;
				best_id_q <= '0;
				best_vr_q <= '0;
				best_wt_q <= '0;
			end
			S_SCAN, S_SCAN2: begin
				if (rd_vld_s1) begin
					if (!valid_q[rd_idx_s1] && !free_ok_q) begin
						free_ok_q <= 1'b1;
						free_q <= rd_idx_s1;
					end
					if (valid_q[rd_idx_s1] && req_q == REQ_DEQ && r_id == id_q) found_q <= 1'b1;
					if (valid_q[rd_idx_s1] && req_q != REQ_DEQ && better) begin
						found_q <= 1'b1;
						best_q <= rd_idx_s1;
						best_id_q <= r_id;
						best_vr_q <= r_vr;
						best_wt_q <= r_wt;
					end
				end
			end
			S_WRITE: begin
				o_id_q <= '0;
				o_vr_q <= '0;
				o_wt_q <= '0;
				o_pre_q <= 1'b0;
				o_st_q <= ST_OK;
				case (req_q)
					REQ_ENQ: if (!free_ok_q) o_st_q <= ST_FULL;
					REQ_DEQ: if (!found_q) o_st_q <= ST_NOID;
					REQ_PICK: begin
						if (!found_q) o_st_q <= ST_EMPTY;
						else begin
							o_id_q <= best_id_q;
							o_vr_q <= best_vr_q;
							o_wt_q <= best_wt_q;
						end
						found_q <= 1'b0;
					end
					REQ_TICK: begin
						o_vr_q <= nv;
						o_pre_q <= found_q && (best_vr_q + VR_W'(gran_q) < nv);
					end
					default: o_st_q <= ST_OK;
				endcase
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q == CW'($countones(valid_q)))
		else $error("count mismatch");
	assert property (@(posedge clk) disable iff (!arst_n) m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n) ram_we |-> !valid_q[ram_waddr])
		else $error("overwrite of live slot");
endmodule

>>> design/fsts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module fsts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> design/fsts_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses fsts_pkg widths; divides a 30-bit numerator by a 20-bit divisor.
module fsts_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [29:0]           num,
	input  logic [fsts_pkg::WT_W-1:0] den,
	output logic                  done,
	output logic [29:0]           quot
);
	import fsts_pkg::*;
	logic [29:0]   q_q;
	logic [WT_W:0] r_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic [WT_W:0] rs;
	logic          ge;

	assign rs = {r_q[WT_W-1:0], q_q[29]};
	assign ge = rs >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd29) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= ge ? rs - {1'b0, den} : rs;
			q_q <= {q_q[28:0], ge};
		end
	end

	assign quot = q_q;
endmodule

>>> test/tb_fair_share_task_scheduler_core.sv
// Testbench for the fair share task scheduler core: directed and random requests
// checked against an in-bench model of the ready table, floor and tick rules.
// Depends on fsts_pkg and the core RTL.
module tb_fair_share_task_scheduler_core;
	timeunit 1ns;
	timeprecision 1ps;
	import fsts_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		logic [19:0] weight;
		logic [63:0] vr;
		logic [7:0]  id;
		req_t        req;
	} sched_req_t;

	typedef struct packed {
		logic [63:0] floor_vr;
		logic [4:0]  count;
		status_t     st;
		logic        preempt;
		logic [19:0] weight;
		logic [63:0] vr;
		logic [7:0]  id;
	} sched_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [95:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [167:0] m_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	fair_share_task_scheduler_core dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// scheduler model state
	logic [19:0] dflt_weight;
	logic [31:0] granularity;
	logic        tbl_valid [DEPTH];
	logic [7:0]  tbl_id [DEPTH];
	logic [63:0] tbl_vr [DEPTH];
	logic [19:0] tbl_weight [DEPTH];
	logic [63:0] floor_vr;

	sched_req_t pending_reqs[$];
	sched_res_t expected_results[$];
	int mismatches = 0;
	int accepted = 0;
	int stall_left = 0;
	int gap_left = 0;
	bit calm = 1'b0;
	bit in_done = 1'b0;
	longint cycles = 0;

	function automatic int head_of_table();
		int best;
		best = -1;
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i] && (best < 0 || tbl_vr[i] < tbl_vr[best] ||
					(tbl_vr[i] == tbl_vr[best] && tbl_id[i] < tbl_id[best])))
				best = i;
		return best;
	endfunction

	function automatic sched_res_t schedule(sched_req_t r);
		sched_res_t o;
		int h;
		int n;
		bit found;
		logic [19:0] w;
		logic [63:0] delta;
		logic [63:0] nv;
		o = '0;
		o.st = ST_OK;
		case (r.req)
			REQ_ENQ: begin
				h = -1;
				for (int i = DEPTH - 1; i >= 0; i--)
					if (!tbl_valid[i])
						h = i;
				if (h < 0) begin
					o.st = ST_FULL;
				end else begin
					tbl_valid[h] = 1'b1;
					tbl_id[h] = r.id;
					tbl_vr[h] = (r.vr == 0) ? floor_vr : r.vr;
					tbl_weight[h] = (r.weight == 0) ? dflt_weight : r.weight;
				end
			end
			REQ_DEQ: begin
				found = 1'b0;
				for (int i = 0; i < DEPTH; i++)
					if (tbl_valid[i] && tbl_id[i] == r.id) begin
						tbl_valid[i] = 1'b0;
						found = 1'b1;
					end
				if (!found)
					o.st = ST_NOID;
			end
			REQ_PICK: begin
				h = head_of_table();
				if (h < 0) begin
					o.st = ST_EMPTY;
				end else begin
					tbl_valid[h] = 1'b0;
					o.id = tbl_id[h];
					o.vr = tbl_vr[h];
					o.weight = tbl_weight[h];
					h = head_of_table();
					floor_vr = (h >= 0) ? tbl_vr[h] : o.vr;
				end
			end
			default: begin
				w = (r.weight == 0) ? dflt_weight : r.weight;
				delta = (w != 0) ? (64'(dflt_weight) * 64'd1000) / 64'(w) : 64'd0;
				nv = r.vr + delta;
				o.vr = nv;
				h = head_of_table();
				o.preempt = (h >= 0) && (tbl_vr[h] + 64'(granularity) < nv);
			end
		endcase
		n = 0;
		for (int i = 0; i < DEPTH; i++)
			if (tbl_valid[i])
				n++;
		o.count = 5'(n);
		o.floor_vr = floor_vr;
		return o;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch on %s: got %0h, expected %0h", what, got, want);
		mismatches++;
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_done) begin
				in_done = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					gap_left = $urandom_range(1, 15);
					s_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					s_tdata <= {2'b00, pending_reqs.pop_front()};
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				stall_left = $urandom_range(1, 15);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// predict on accepted requests, check results
	always @(posedge clk) begin
		sched_res_t got;
		sched_res_t want;
		cycles++;
		if (s_tvalid && s_tready) begin
			accepted++;
			in_done = 1'b1;
			expected_results = {expected_results, schedule(sched_req_t'(s_tdata[93:0]))};
		end
		if (m_tvalid && m_tready) begin
			got = sched_res_t'(m_tdata[163:0]);
			if (expected_results.size() == 0) begin
				report("unexpected result", m_tdata[63:0], 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.id != want.id) report("task id", got.id, want.id);
				if (got.vr != want.vr) report("vruntime", got.vr, want.vr);
				if (got.weight != want.weight) report("weight", got.weight, want.weight);
				if (got.preempt != want.preempt)
					report("preempt", got.preempt, want.preempt);
				if (got.st != want.st) report("status", got.st, want.st);
				if (got.count != want.count) report("count", got.count, want.count);
				if (got.floor_vr != want.floor_vr)
					report("floor", got.floor_vr, want.floor_vr);
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 2_000_000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic sched_req_t mk(req_t q, logic [7:0] id, logic [63:0] vr,
			logic [19:0] w);
		sched_req_t r;
		r.req = q;
		r.id = id;
		r.vr = vr;
		r.weight = w;
		return r;
	endfunction

	function automatic logic [63:0] rnd_vr();
		case ($urandom_range(0, 5))
			0: return 64'd0;
			1: return '1 - 64'($urandom_range(0, 3000));
			2: return {$urandom, $urandom};
			default: return 64'($urandom_range(1, 20000));
		endcase
	endfunction

	function automatic logic [19:0] rnd_weight();
		case ($urandom_range(0, 4))
			0: return 20'd0;
			1: return 20'hFFFFF;
			2: return 20'($urandom);
			default: return 20'($urandom_range(1, 3000));
		endcase
	endfunction

	task automatic drain();
		wait (pending_reqs.size() == 0 && !s_tvalid);
		wait (expected_results.size() == 0);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_WEIGHT)
			dflt_weight = val[19:0];
		else
			granularity = val;
	endtask

	task automatic random_phase(int n);
		int pool;
		req_t q;
		pool = $urandom_range(3, 40);
		for (int i = 0; i < n; i++) begin
			q = req_t'($urandom_range(0, 3));
			if ($urandom_range(0, 3) == 0) q = REQ_ENQ;
			pending_reqs = {pending_reqs, mk(q, 8'($urandom_range(0, pool)) |
				(($urandom_range(0, 9) == 0) ? 8'hF0 : 8'h00), rnd_vr(), rnd_weight())};
		end
	endtask

	initial begin
		dflt_weight = 20'd1024;
		granularity = 32'd4000;
		floor_vr = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_id[i] = '0;
			tbl_vr[i] = '0;
			tbl_weight[i] = '0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// directed: empty pick, tick with empty table, fill past full, duplicates
		pending_reqs = {pending_reqs, mk(REQ_PICK, 8'd0, 64'd0, 20'd0)};
		pending_reqs = {pending_reqs, mk(REQ_TICK, 8'd0, 64'd100, 20'd0)};
		pending_reqs = {pending_reqs, mk(REQ_DEQ, 8'd9, 64'd0, 20'd0)};
		for (int i = 0; i < 17; i++)
			pending_reqs = {pending_reqs, mk(REQ_ENQ, (i == 3) ? 8'hFF : 8'(i % 8),
				(i == 0) ? 64'd0 : (i == 1 ? '1 : 64'(5000 - i * 100)),
				(i == 2) ? 20'hFFFFF : 20'(i % 2))};
		pending_reqs = {pending_reqs, mk(REQ_TICK, 8'd0, 64'hFFFF_FFFF_FFFF_FFF0, 20'd1)};
		pending_reqs = {pending_reqs, mk(REQ_TICK, 8'd0, 64'd9000, 20'hFFFFF)};
		pending_reqs = {pending_reqs, mk(REQ_DEQ, 8'd5, 64'd0, 20'd0)};
		pending_reqs = {pending_reqs, mk(REQ_PICK, 8'd0, 64'd0, 20'd0)};
		drain();
		random_phase(250);
		drain();
		write_reg(CFG_WEIGHT, 32'd0);
		write_reg(CFG_GRAN, 32'd0);
		random_phase(200);
		drain();
		write_reg(CFG_WEIGHT, 32'hFFFFF);
		write_reg(CFG_GRAN, 32'hFFFF_FFFF);
		random_phase(200);
		drain();
		write_reg(CFG_WEIGHT, 32'd1);
		write_reg(CFG_GRAN, 32'd50);
		random_phase(200);
		drain();
		write_reg(CFG_WEIGHT, 32'($urandom_range(1, 5000)));
		write_reg(CFG_GRAN, $urandom);
		calm = 1'b1;
		random_phase(180);
		drain();
		if (expected_results.size() == 0 && mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
